>>> rtl/core/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for seconds_to_calendar_text
// Holds the constant-divide reciprocals, the month tables and the ASCII
// helpers used by the time split, month search and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    // Field widths
    localparam int unsigned SECS_W  = 25;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;

    // Calendar constants
    localparam logic [DOY_W-1:0] DAYS_PER_YEAR = 9'd365;
    localparam int unsigned      MONTH_COUNT   = 12;

    // Reciprocals for exact floor division of a 25-bit count:
    // q = (t * ceil(2^k / d)) >> k with k = 25 + ceil(log2(d)).
    localparam int unsigned  RECIP_W    = 26;
    localparam int unsigned  PROD_W     = SECS_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MIN  = 26'd35791395;  // d = 60,    k = 31
    localparam logic [RECIP_W-1:0] RECIP_HOUR = 26'd38177488;  // d = 3600,  k = 37
    localparam logic [RECIP_W-1:0] RECIP_DAY  = 26'd50903317;  // d = 86400, k = 42

    // ASCII codes
    localparam logic [7:0]  ASCII_ZERO   = 8'h30;
    localparam logic [23:0] SPACES_3     = 24'h202020;
    localparam logic [15:0] SPACES_2     = 16'h2020;

    // Split parts of the count
    typedef struct packed {
        logic [5:0]       sec;
        logic [5:0]       min;
        logic [4:0]       hour;
        logic [DOY_W-1:0] doy;
    } t_time_parts;

    // Month search result
    typedef struct packed {
        logic               oor;
        logic [MONTH_W-1:0] month;   // 1..12, 0 when out of range
        logic [DAY_W-1:0]   day;     // 1..31, 0 when out of range
    } t_date;

    // First day of year (0-based) of each month, index 0 = January
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
        logic [DOY_W-1:0] s;
        begin
            case (idx)
                4'd0:    s = 9'd0;
                4'd1:    s = 9'd31;
                4'd2:    s = 9'd59;
                4'd3:    s = 9'd90;
                4'd4:    s = 9'd120;
                4'd5:    s = 9'd151;
                4'd6:    s = 9'd181;
                4'd7:    s = 9'd212;
                4'd8:    s = 9'd243;
                4'd9:    s = 9'd273;
                4'd10:   s = 9'd304;
                4'd11:   s = 9'd334;
                default: s = 9'd0;
            endcase
            return s;
        end
    endfunction

    // Three-letter name of a month, 1 = JAN
    function automatic logic [23:0] month_letters(input logic [MONTH_W-1:0] month);
        logic [23:0] n;
        begin
            case (month)
                4'd1:    n = 24'h4A414E;  // JAN
                4'd2:    n = 24'h464542;  // FEB
                4'd3:    n = 24'h4D4152;  // MAR
                4'd4:    n = 24'h415052;  // APR
                4'd5:    n = 24'h4D4159;  // MAY
                4'd6:    n = 24'h4A554E;  // JUN
                4'd7:    n = 24'h4A554C;  // JUL
                4'd8:    n = 24'h415547;  // AUG
                4'd9:    n = 24'h534550;  // SEP
                4'd10:   n = 24'h4F4354;  // OCT
                4'd11:   n = 24'h4E4F56;  // NOV
                4'd12:   n = 24'h444543;  // DEC
                default: n = SPACES_3;
            endcase
            return n;
        end
    endfunction

    // Two ASCII digits of a value 0..99, tens in the upper byte.
    // tens = (v * 103) >> 10 is exact over 0..99.
    function automatic logic [15:0] two_digits(input logic [6:0] v);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [7:0]  tens_x10;
        logic [3:0]  ones;
        begin
            prod     = 14'(v) * 14'd103;
            tens     = prod[13:10];
            tens_x10 = 8'(tens) * 8'd10;
            ones     = 4'(8'(v) - tens_x10);
            return {ASCII_ZERO + 8'(tens), ASCII_ZERO + 8'(ones)};
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/stc_time_split.sv
// ----------------------------------------------------------------------------
// stc_time_split: seconds count to second, minute, hour and day of year
// Three parallel constant-reciprocal multiplies give the quotients by 60,
// 3600 and 86400; remainders come from narrow back-multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_time_split (
    input  wire logic [stc_pkg::SECS_W-1:0] i_secs,
    output stc_pkg::t_time_parts            o_parts
);

    logic [stc_pkg::PROD_W-1:0] prod_min;
    logic [stc_pkg::PROD_W-1:0] prod_hour;
    logic [stc_pkg::PROD_W-1:0] prod_day;
    logic [19:0]                q_min;    // t / 60, max 559240
    logic [13:0]                q_hour;   // t / 3600, max 9320
    logic [8:0]                 q_day;    // t / 86400, max 388
    logic [11:0]                back_sec;
    logic [11:0]                back_min;
    logic [9:0]                 back_hour;

    // Quotients by reciprocal multiply
    assign prod_min  = stc_pkg::PROD_W'(i_secs) * stc_pkg::PROD_W'(stc_pkg::RECIP_MIN);
    assign prod_hour = stc_pkg::PROD_W'(i_secs) * stc_pkg::PROD_W'(stc_pkg::RECIP_HOUR);
    assign prod_day  = stc_pkg::PROD_W'(i_secs) * stc_pkg::PROD_W'(stc_pkg::RECIP_DAY);

    assign q_min  = prod_min[50:31];
    assign q_hour = prod_hour[50:37];
    assign q_day  = prod_day[50:42];

    // Remainders: only the low bits matter since each result is below 64
    assign back_sec  = 12'(q_min[5:0])  * 12'd60;
    assign back_min  = 12'(q_hour[5:0]) * 12'd60;
    assign back_hour = 10'(q_day[4:0])  * 10'd24;

    assign o_parts.sec  = i_secs[5:0] - back_sec[5:0];
    assign o_parts.min  = q_min[5:0]  - back_min[5:0];
    assign o_parts.hour = q_hour[4:0] - back_hour[4:0];
    assign o_parts.doy  = q_day;

endmodule

`default_nettype wire

>>> rtl/core/stc_month_find.sv
// ----------------------------------------------------------------------------
// stc_month_find: day of year to month and day of month
// Eleven parallel compares against the month start table pick the month;
// the day follows by one subtract. Days past the year flag out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_month_find (
    input  wire logic [stc_pkg::DOY_W-1:0] i_doy,
    output stc_pkg::t_date                 o_date
);

    logic [stc_pkg::MONTH_W-1:0] idx;
    logic [stc_pkg::DOY_W-1:0]   offset;
    logic                        oor;

    // Last month whose first day is not past the day of year
    always_comb begin
        idx = '0;
        for (int i = 1; i < stc_pkg::MONTH_COUNT; i++) begin
            if (i_doy >= stc_pkg::month_start(stc_pkg::MONTH_W'(i))) begin
                idx = stc_pkg::MONTH_W'(i);
            end
        end
    end

    assign oor    = (i_doy >= stc_pkg::DAYS_PER_YEAR);
    assign offset = i_doy - stc_pkg::month_start(idx);

    assign o_date.oor   = oor;
    assign o_date.month = oor ? '0 : idx + 4'd1;
    assign o_date.day   = oor ? '0 : offset[stc_pkg::DAY_W-1:0] + 5'd1;

endmodule

`default_nettype wire

>>> rtl/core/seconds_to_calendar_text.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar_text: seconds of a non-leap year to calendar text
// Splits a seconds count into month, day, hour, minute and second and
// formats them as ASCII; counts of a year or more raise out_of_range.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------
//  in      | in  | i_valid / o_stall | i_elapsed_seconds[24:0]
//  out     | out | o_valid / i_stall | o_month_name .. o_out_of_range
//
// One word per clock sustained while i_stall is low; an accepted word passes
// the input register, then the result register. The whole conversion sits in
// one combinational pass; the three reciprocal multiplies set its depth.
// Reset (i_rst_n low, synchronous) empties both registers.
// o_stall rises only when both registers hold a word and i_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_to_calendar_text (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [24:0] i_elapsed_seconds,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [23:0]      o_month_name,
    output logic [15:0]      o_day_text,
    output logic [15:0]      o_hour_text,
    output logic [15:0]      o_minute_text,
    output logic [15:0]      o_second_text,
    output logic [3:0]       o_month_number,
    output logic [4:0]       o_day_of_month,
    output logic             o_out_of_range
);

    logic                          r_in_valid;
    logic [stc_pkg::SECS_W-1:0]    r_in_secs;
    logic                          r_out_valid;
    logic [23:0]                   r_month_name;
    logic [15:0]                   r_day_text;
    logic [15:0]                   r_hour_text;
    logic [15:0]                   r_minute_text;
    logic [15:0]                   r_second_text;
    logic [stc_pkg::MONTH_W-1:0]   r_month_number;
    logic [stc_pkg::DAY_W-1:0]     r_day_of_month;
    logic                          r_out_of_range;

    logic                          n_in_valid;
    logic                          n_out_valid;
    logic                          out_adv;
    logic                          in_adv;
    stc_pkg::t_time_parts          parts;
    stc_pkg::t_date                date;

    // Flow control: each register moves when its successor can take a word
    assign out_adv     = !r_out_valid || !i_stall;
    assign in_adv      = !r_in_valid || out_adv;
    assign o_stall     = !in_adv;
    assign n_in_valid  = in_adv ? i_valid : r_in_valid;
    assign n_out_valid = out_adv ? r_in_valid : r_out_valid;

    // Conversion datapath
    stc_time_split u_split (
        .i_secs  (r_in_secs),
        .o_parts (parts)
    );

    stc_month_find u_month (
        .i_doy  (parts.doy),
        .o_date (date)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (in_adv && i_valid) begin
            r_in_secs <= i_elapsed_seconds;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (out_adv && r_in_valid) begin
            r_month_name   <= date.oor ? stc_pkg::SPACES_3
                                       : stc_pkg::month_letters(date.month);
            r_day_text     <= date.oor ? stc_pkg::SPACES_2
                                       : stc_pkg::two_digits(7'(date.day));
            r_hour_text    <= stc_pkg::two_digits(7'(parts.hour));
            r_minute_text  <= stc_pkg::two_digits(7'(parts.min));
            r_second_text  <= stc_pkg::two_digits(7'(parts.sec));
            r_month_number <= date.month;
            r_day_of_month <= date.day;
            r_out_of_range <= date.oor;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_month_name   = r_month_name;
    assign o_day_text     = r_day_text;
    assign o_hour_text    = r_hour_text;
    assign o_minute_text  = r_minute_text;
    assign o_second_text  = r_second_text;
    assign o_month_number = r_month_number;
    assign o_day_of_month = r_day_of_month;
    assign o_out_of_range = r_out_of_range;

    // Checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled while a register is free");

    a_word_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_adv) |=> r_out_valid)
        else $error("word lost between input and result register");

    a_oor_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_of_range) |->
            (r_month_number == '0 && r_day_of_month == '0))
        else $error("out of range result with nonzero month or day");

    a_date_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_of_range) |->
            (r_month_number >= 4'd1 && r_month_number <= 4'd12 &&
             r_day_of_month >= 5'd1 && r_day_of_month <= 5'd31))
        else $error("month or day outside calendar bounds");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for seconds_to_calendar_text
// Walks a table of calendar corner cases, then sends random second counts,
// most in range, some near month edges and some past the end of the year.
// Every output word is checked field by field against a table answer or an
// in-bench calendar model. Both sides idle at random; the receiver holds
// off once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECS_W      = stc_pkg::SECS_W;
    localparam int unsigned SECS_MIN    = 60;
    localparam int unsigned SECS_HOUR   = 3600;
    localparam int unsigned SECS_DAY    = 86400;
    localparam int unsigned YEAR_DAYS   = 365;
    localparam int unsigned YEAR_SECS   = YEAR_DAYS * SECS_DAY;
    localparam int          RANDOM_WORDS = 1627;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          HOLD_AFTER   = 400;
    localparam int          STEADY_FIRST = 1000;
    localparam int          STEADY_LAST  = 1120;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 1_000_000;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};
    localparam logic [23:0] MONTH_TAGS [12] = '{"JAN", "FEB", "MAR", "APR",
                                                "MAY", "JUN", "JUL", "AUG",
                                                "SEP", "OCT", "NOV", "DEC"};

    // One output word of the block
    typedef struct packed {
        logic [23:0] month_name;
        logic [15:0] day_text;
        logic [15:0] hour_text;
        logic [15:0] minute_text;
        logic [15:0] second_text;
        logic [3:0]  month_number;
        logic [4:0]  day_of_month;
        logic        out_of_range;
    } t_calendar_word;

    // Directed probe: count, plus a hand-written answer where one is given
    typedef struct packed {
        logic              has_answer;
        logic [SECS_W-1:0] secs;
        t_calendar_word    answer;
    } t_probe;

    localparam t_calendar_word NO_ANSWER = '0;
    localparam int             PROBE_COUNT = 23;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [SECS_W-1:0] i_elapsed_seconds = '0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [23:0]       o_month_name;
    logic [15:0]       o_day_text;
    logic [15:0]       o_hour_text;
    logic [15:0]       o_minute_text;
    logic [15:0]       o_second_text;
    logic [3:0]        o_month_number;
    logic [4:0]        o_day_of_month;
    logic              o_out_of_range;

    t_calendar_word due_calendars [$];
    t_calendar_word want;
    t_probe         probes [PROBE_COUNT];
    int             mismatches = 0;
    int             words_sent = 0;
    int             words_seen = 0;
    int             cycles = 0;
    bit             steady = 1'b0;
    bit             held_off = 1'b0;

    seconds_to_calendar_text i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_elapsed_seconds (i_elapsed_seconds),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_month_name      (o_month_name),
        .o_day_text        (o_day_text),
        .o_hour_text       (o_hour_text),
        .o_minute_text     (o_minute_text),
        .o_second_text     (o_second_text),
        .o_month_number    (o_month_number),
        .o_day_of_month    (o_day_of_month),
        .o_out_of_range    (o_out_of_range)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Two ASCII digits, tens in the upper byte
    function automatic logic [15:0] ascii_pair(input int unsigned v);
        logic [7:0] tens;
        logic [7:0] ones;
        tens = 8'((v / 10) % 10) + "0";
        ones = 8'(v % 10) + "0";
        return {tens, ones};
    endfunction

    // Calendar position and text for a seconds count
    function automatic t_calendar_word calendar_of(input logic [SECS_W-1:0] secs);
        t_calendar_word w;
        int unsigned    t;
        int unsigned    doy;
        int unsigned    mon;
        t   = secs;
        doy = t / SECS_DAY;
        mon = 0;
        // walk the month lengths until the day falls inside one
        if (doy < YEAR_DAYS) begin
            for (int m = 0; m < 12; m++) begin
                if (doy < MONTH_DAYS[m]) begin
                    mon = m + 1;
                    break;
                end
                doy -= MONTH_DAYS[m];
            end
        end
        if (mon != 0) begin
            w.month_name   = MONTH_TAGS[mon-1];
            w.day_text     = ascii_pair(doy + 1);
            w.month_number = 4'(mon);
            w.day_of_month = 5'(doy + 1);
            w.out_of_range = 1'b0;
        end else begin
            w.month_name   = "   ";
            w.day_text     = "  ";
            w.month_number = '0;
            w.day_of_month = '0;
            w.out_of_range = 1'b1;
        end
        w.hour_text   = ascii_pair((t / SECS_HOUR) % 24);
        w.minute_text = ascii_pair((t / SECS_MIN) % 60);
        w.second_text = ascii_pair(t % SECS_MIN);
        return w;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random count: in range, near a month edge, past the year, or any 25 bits
    function automatic logic [SECS_W-1:0] random_secs();
        int          r;
        int unsigned first_day;
        int unsigned base;
        int unsigned offs;
        int          month;
        r = $urandom_range(0, 99);
        if (r < 60) return SECS_W'($urandom_range(0, YEAR_SECS - 1));
        if (r < 75) begin
            month = $urandom_range(0, 11);
            first_day = 0;
            for (int m = 0; m < month; m++) first_day += MONTH_DAYS[m];
            base = first_day * SECS_DAY;
            offs = $urandom_range(0, 2 * SECS_HOUR - 1);
            // straddle the first midnight of the month
            if (base + offs < SECS_HOUR) return SECS_W'(offs);
            return SECS_W'(base + offs - SECS_HOUR);
        end
        if (r < 88) return SECS_W'($urandom_range(YEAR_SECS, (1 << SECS_W) - 1));
        return SECS_W'($urandom());
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        $display("MISMATCH word %0d %s: got %h want %h", words_seen, what, got, exp_val);
        mismatches++;
    endtask

    // Offer one word and hold it until accepted
    task automatic send_word(input logic [SECS_W-1:0] secs, input t_calendar_word w);
        int gap;
        gap = steady ? 0 : pause_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_elapsed_seconds <= secs;
        do @(posedge i_clk); while (o_stall);
        due_calendars.push_back(w);
        words_sent++;
    endtask

    // Stimulus: reset, probe table, random counts, drain
    initial begin
        probes = '{
            '{1'b1, 25'd0,        '{"JAN", "01", "00", "00", "00", 4'd1,  5'd1,  1'b0}},
            '{1'b1, 25'd59,       '{"JAN", "01", "00", "00", "59", 4'd1,  5'd1,  1'b0}},
            '{1'b1, 25'd86399,    '{"JAN", "01", "23", "59", "59", 4'd1,  5'd1,  1'b0}},
            '{1'b1, 25'd5097600,  '{"MAR", "01", "00", "00", "00", 4'd3,  5'd1,  1'b0}},
            '{1'b1, 25'd31535999, '{"DEC", "31", "23", "59", "59", 4'd12, 5'd31, 1'b0}},
            '{1'b1, 25'd31536000, '{"   ", "  ", "00", "00", "00", 4'd0,  5'd0,  1'b1}},
            '{1'b1, 25'd33554431, '{"   ", "  ", "08", "40", "31", 4'd0,  5'd0,  1'b1}},
            '{1'b0, 25'd60,       NO_ANSWER},
            '{1'b0, 25'd3599,     NO_ANSWER},
            '{1'b0, 25'd2678399,  NO_ANSWER},
            '{1'b0, 25'd2678400,  NO_ANSWER},
            '{1'b0, 25'd5097599,  NO_ANSWER},
            '{1'b0, 25'd7776000,  NO_ANSWER},
            '{1'b0, 25'd10368000, NO_ANSWER},
            '{1'b0, 25'd13046400, NO_ANSWER},
            '{1'b0, 25'd15638400, NO_ANSWER},
            '{1'b0, 25'd18316800, NO_ANSWER},
            '{1'b0, 25'd20995200, NO_ANSWER},
            '{1'b0, 25'd23587200, NO_ANSWER},
            '{1'b0, 25'd26265600, NO_ANSWER},
            '{1'b0, 25'd28857600, NO_ANSWER},
            '{1'b0, 25'd16777215, NO_ANSWER},
            '{1'b0, 25'd16777216, NO_ANSWER}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[k]) begin
            send_word(probes[k].secs,
                      probes[k].has_answer ? probes[k].answer
                                           : calendar_of(probes[k].secs));
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            logic [SECS_W-1:0] secs;
            secs   = random_secs();
            // a stretch with no idling on either side
            steady = (words_sent >= STEADY_FIRST) && (words_sent < STEADY_LAST);
            send_word(secs, calendar_of(secs));
        end
        steady = 1'b0;

        i_valid <= 1'b0;
        while (due_calendars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("seconds_to_calendar_text verification clean");
        end else begin
            $display("seconds_to_calendar_text verification failed");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off
    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held_off && words_sent >= HOLD_AFTER) begin
                i_stall <= 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
                held_off = 1'b1;
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (steady) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                int n;
                n = pause_len();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Output check against the oldest expected word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_calendars.size() == 0) begin
                note_mismatch("word with none pending", 32'(o_month_name), '0);
            end else begin
                want = due_calendars.pop_front();
                if (o_month_name !== want.month_name)
                    note_mismatch("month_name", 32'(o_month_name), 32'(want.month_name));
                if (o_day_text !== want.day_text)
                    note_mismatch("day_text", 32'(o_day_text), 32'(want.day_text));
                if (o_hour_text !== want.hour_text)
                    note_mismatch("hour_text", 32'(o_hour_text), 32'(want.hour_text));
                if (o_minute_text !== want.minute_text)
                    note_mismatch("minute_text", 32'(o_minute_text), 32'(want.minute_text));
                if (o_second_text !== want.second_text)
                    note_mismatch("second_text", 32'(o_second_text), 32'(want.second_text));
                if (o_month_number !== want.month_number)
                    note_mismatch("month_number", 32'(o_month_number),
                                  32'(want.month_number));
                if (o_day_of_month !== want.day_of_month)
                    note_mismatch("day_of_month", 32'(o_day_of_month),
                                  32'(want.day_of_month));
                if (o_out_of_range !== want.out_of_range)
                    note_mismatch("out_of_range", 32'(o_out_of_range),
                                  32'(want.out_of_range));
            end
            words_seen++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("seconds_to_calendar_text verification failed");
            $finish;
        end
    end

endmodule

`default_nettype wire

>>> files.f
rtl/core/stc_pkg.sv
rtl/core/stc_time_split.sv
rtl/core/stc_month_find.sv
rtl/core/seconds_to_calendar_text.sv
dv/tb_top.sv
